FILE: hw/rtl/brlt_pkg.sv
package brlt_pkg;

   localparam int OFF_W          = 64;
   localparam int STATUS_W       = 3;
   localparam int USE_W          = 5;
   localparam int DEF_MAX_RANGES = 16;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_BLOCKED  = 3'd1,
      STATUS_RELEASED = 3'd2,
      STATUS_NOSUCH   = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FINISH
   } state_type;

   typedef enum logic {
      MODE_LOCK   = 1'b0,
      MODE_UNLOCK = 1'b1
   } mode_type;

   typedef struct packed {
      logic overlap;
      logic exact;
   } match_type;

endpackage

FILE: hw/rtl/byte_range_lock_table_unit.sv
// Channel   Dir  Beat fields                          Handshake
// req_      in   mode, range_low, range_high          req_valid / req_stall
// rsp_      out  status, entries_in_use               rsp_valid / rsp_stall
//
// One request at a time. A request scans the held entries through the table
// RAM read port, one entry per cycle, comparing each entry once its registered
// read data returns; a release then also moves the last entry into the freed slot.
// Reset empties the table by clearing the entry count; no RAM sweep is needed.
// A new request is taken while a finished response still waits; a stalled
// response holds the next one in its final step.
module byte_range_lock_table_unit #(
   parameter int MAX_RANGES = brlt_pkg::DEF_MAX_RANGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [brlt_pkg::OFF_W-1:0]    req_range_low,
   input  logic [brlt_pkg::OFF_W-1:0]    req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brlt_pkg::STATUS_W-1:0] rsp_status,
   output logic [brlt_pkg::USE_W-1:0]    rsp_entries_in_use
);
   import brlt_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int ENT_W = 2 * OFF_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   status_type         result_ff, result_in;
   logic               mode_ff;
   logic [OFF_W-1:0]   low_ff, high_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [CNT_W-1:0]   use_ff, use_in;

   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]   ram_wr_data, ram_rd_data;
   match_type          match;
   logic               accept, issue, hit;
   logic [CNT_W-1:0]   last;
   logic [CNT_W+USE_W-1:0] use_ext;

   brlt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_RANGES),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   brlt_match u_match (
      .entry_low  (ram_rd_data[OFF_W-1:0]),
      .entry_high (ram_rd_data[ENT_W-1:OFF_W]),
      .req_low    (low_ff),
      .req_high   (high_ff),
      .result     (match)
   );

   assign accept = req_valid && !req_stall;
   assign issue  = idx_ff < count_ff;
   assign hit    = rd_vld_ff && ((mode_ff == MODE_LOCK) ? match.overlap : match.exact);
   assign last   = count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_idx_ff  <= rd_idx_in;
      hit_idx_ff <= hit_idx_in;
      result_ff  <= result_in;
      status_ff  <= status_in;
      use_ff     <= use_in;
      if (accept) begin
         mode_ff <= req_mode;
         low_ff  <= req_range_low;
         high_ff <= req_range_high;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_idx_in   = hit_idx_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      use_in       = use_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IDX_W-1:0];
      ram_wr_data  = {high_ff, low_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[IDX_W-1:0];
      req_stall    = 1'b1;
      // drop the response once the beat is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               if (mode_ff == MODE_LOCK) begin
                  result_in = STATUS_BLOCKED;
                  state_in  = ST_FINISH;
               end else begin
                  hit_idx_in = rd_idx_ff;
                  state_in   = ST_MOVE_RD;
               end
            end else if (issue) begin
               // fetch the next entry; compare it in the following cycle
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
               if (mode_ff == MODE_UNLOCK) begin
                  result_in = STATUS_NOSUCH;
               end else if (count_ff == CNT_W'(MAX_RANGES)) begin
                  result_in = STATUS_FULL;
               end else begin
                  // append at the end of the table
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  result_in = STATUS_GRANTED;
               end
            end
         end
         ST_MOVE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = last[IDX_W-1:0];
            state_in    = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // move the last entry into the freed slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_idx_ff;
            ram_wr_data = ram_rd_data;
            count_in    = last;
            result_in   = STATUS_RELEASED;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               status_in    = result_ff;
               use_in       = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign use_ext            = {{USE_W{1'b0}}, use_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_entries_in_use = use_ext[USE_W-1:0];

endmodule

FILE: hw/rtl/brlt_ram.sv
module brlt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/brlt_match.sv
module brlt_match (
   input  logic [brlt_pkg::OFF_W-1:0] entry_low,
   input  logic [brlt_pkg::OFF_W-1:0] entry_high,
   input  logic [brlt_pkg::OFF_W-1:0] req_low,
   input  logic [brlt_pkg::OFF_W-1:0] req_high,
   output brlt_pkg::match_type        result
);
   import brlt_pkg::*;

   logic entry_nonempty;
   logic req_nonempty;

   assign entry_nonempty = entry_low < entry_high;
   assign req_nonempty   = req_low < req_high;

   // empty ranges never overlap anything
   assign result.overlap = entry_nonempty && req_nonempty
                           && (req_low < entry_high) && (entry_low < req_high);
   assign result.exact   = (entry_low == req_low) && (entry_high == req_high);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import brlt_pkg::*;

   localparam int TABLE_DEPTH  = DEF_MAX_RANGES;
   localparam int GEN          = 0;
   localparam int CHK          = 1;
   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 50;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 600;
   localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

   typedef struct {
      mode_type         mode;
      logic [OFF_W-1:0] low;
      logic [OFF_W-1:0] high;
      bit               drain;
   } lock_req_type;

   typedef struct {
      status_type       status;
      logic [USE_W-1:0] used;
   } lock_rsp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = 1'b0;
   logic [OFF_W-1:0]    req_range_low = '0;
   logic [OFF_W-1:0]    req_range_high = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [USE_W-1:0]    rsp_entries_in_use;

   // two copies of the table: one steers stimulus, one predicts responses
   logic [OFF_W-1:0] held_lo [2][TABLE_DEPTH];
   logic [OFF_W-1:0] held_hi [2][TABLE_DEPTH];
   int unsigned      held_cnt [2];

   lock_req_type   lock_request_q [$];
   lock_rsp_type   lock_status_q [$];
   lock_req_type   offered;
   int          mismatch_count = 0;
   int unsigned rsps_accepted = 0;
   int          burst_left = 1;
   int          gap_left = 0;

   byte_range_lock_table_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_range_low      (req_range_low),
      .req_range_high     (req_range_high),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit ranges_overlap(input logic [OFF_W-1:0] a_lo, a_hi, b_lo, b_hi);
      if (a_lo >= a_hi || b_lo >= b_hi) return 1'b0;
      return (a_hi > b_lo) && (b_hi > a_lo);
   endfunction

   function automatic void update_lock_table(input int m, input mode_type md,
                                             input logic [OFF_W-1:0] lo, hi,
                                             output status_type st,
                                             output logic [USE_W-1:0] used);
      int found;
      int unsigned last;
      found = -1;
      if (md == MODE_LOCK) begin
         st = STATUS_GRANTED;
         for (int i = 0; i < held_cnt[m]; i++)
            if (ranges_overlap(held_lo[m][i], held_hi[m][i], lo, hi)) st = STATUS_BLOCKED;
         if (st != STATUS_BLOCKED) begin
            if (held_cnt[m] >= TABLE_DEPTH) begin
               st = STATUS_FULL;
            end else begin
               held_lo[m][held_cnt[m]] = lo;
               held_hi[m][held_cnt[m]] = hi;
               held_cnt[m]++;
            end
         end
      end else begin
         st = STATUS_NOSUCH;
         for (int i = held_cnt[m] - 1; i >= 0; i--)
            if (held_lo[m][i] == lo && held_hi[m][i] == hi) found = i;
         if (found >= 0) begin
            // fill the hole with the last entry
            last = held_cnt[m] - 1;
            held_lo[m][found] = held_lo[m][last];
            held_hi[m][found] = held_hi[m][last];
            held_cnt[m] = last;
            st = STATUS_RELEASED;
         end
      end
      used = held_cnt[m][USE_W-1:0];
   endfunction

   task automatic add_req(input mode_type md, input logic [OFF_W-1:0] lo, hi,
                          input bit drain);
      lock_req_type r;
      status_type st;
      logic [USE_W-1:0] used;
      r.mode  = md;
      r.low   = lo;
      r.high  = hi;
      r.drain = drain;
      lock_request_q.insert(lock_request_q.size(), r);
      update_lock_table(GEN, md, lo, hi, st, used);
   endtask

   function automatic logic [OFF_W-1:0] rand_off();
      return {$urandom, $urandom};
   endfunction

   // driver: bursts of beats separated by random gaps
   always @(posedge clock) begin
      bit sent;
      status_type st;
      logic [USE_W-1:0] used;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent = req_valid && !req_stall;
         if (sent) begin
            update_lock_table(CHK, offered.mode, offered.low, offered.high, st, used);
            lock_status_q.insert(lock_status_q.size(),
                                 lock_rsp_type'{status: st, used: used});
         end
         if (!req_valid || sent) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (lock_request_q.size() > 0 &&
                         !(lock_request_q[0].drain && lock_status_q.size() > 0)) begin
               offered = lock_request_q.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= offered.mode;
               req_range_low  <= offered.low;
               req_range_high <= offered.high;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: a changing pattern, plus one long hold-off
   always @(posedge clock) begin
      int unsigned cyc;
      int          style;
      int          hold_left;
      bit          hold_done;
      bit          stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         cyc = 0;
         style = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         cyc++;
         if (cyc % 256 == 0) style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && rsps_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            stall_next = 1'b1;
         end else begin
            case (style)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 3) == 0);
               2: stall_next = cyc[2];
               default: stall_next = ($urandom_range(0, 9) < 7);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      lock_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_accepted++;
         if (lock_status_q.size() == 0) begin
            $display("%0t: response with none expected, status %0d entries %0d",
                     $time, rsp_status, rsp_entries_in_use);
            mismatch_count++;
         end else begin
            want = lock_status_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_entries_in_use !== want.used) begin
               $display("%0t: entries_in_use expected %0d, actual %0d",
                        $time, want.used, rsp_entries_in_use);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int idle;
      if (reset) begin
         idle = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("FAIL byte_range_lock_table_unit");
            $finish;
         end
      end
   end

   initial begin
      int               lock_weight;
      int               sel;
      int unsigned      idx;
      logic [OFF_W-1:0] base;
      logic [OFF_W-1:0] lo;
      logic [OFF_W-1:0] hi;
      mode_type         md;

      held_cnt[GEN] = 0;
      held_cnt[CHK] = 0;

      add_req(MODE_LOCK,   '0, OFF_MAX, 1'b0);
      add_req(MODE_LOCK,   OFF_MAX - 1, OFF_MAX, 1'b0);
      add_req(MODE_LOCK,   OFF_MAX, OFF_MAX, 1'b0);    // empty range
      add_req(MODE_UNLOCK, '0, OFF_MAX, 1'b0);
      add_req(MODE_UNLOCK, '0, OFF_MAX, 1'b0);         // no longer held
      add_req(MODE_LOCK,   OFF_MAX, '0, 1'b0);         // low above high
      add_req(MODE_LOCK,   64'd10, 64'd20, 1'b0);
      add_req(MODE_LOCK,   64'd20, 64'd30, 1'b0);      // touches, no overlap
      add_req(MODE_LOCK,   64'd5, 64'd11, 1'b0);
      add_req(MODE_LOCK,   64'd19, 64'd21, 1'b0);
      add_req(MODE_LOCK,   64'd15, 64'd15, 1'b0);      // empty inside a held range
      add_req(MODE_LOCK,   64'd10, 64'd20, 1'b0);
      add_req(MODE_UNLOCK, 64'd10, 64'd20, 1'b0);
      add_req(MODE_UNLOCK, 64'd15, 64'd16, 1'b1);
      // duplicates of an empty range fill the table and then hit full
      for (int i = 0; i < 13; i++) add_req(MODE_LOCK, 64'd7, 64'd7, 1'b0);
      add_req(MODE_LOCK,   64'd25, 64'd26, 1'b0);      // overlap while full
      add_req(MODE_UNLOCK, 64'd7, 64'd7, 1'b0);        // lowest duplicate goes

      lock_weight = 5;
      base = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            lock_weight = ($urandom_range(0, 1) == 0) ? 7 : 3;
            case ($urandom_range(0, 2))
               0: base = '0;
               1: base = OFF_MAX - 64'h1FF - 64'h1_0000;
               default: base = rand_off() >> 1;
            endcase
         end
         md = ($urandom_range(0, 9) < lock_weight) ? MODE_LOCK : MODE_UNLOCK;
         sel = $urandom_range(0, 7);
         if (md == MODE_LOCK) begin
            case (sel)
               0, 1, 2: begin
                  lo = base + $urandom_range(0, 300);
                  hi = lo + $urandom_range(0, 20);
               end
               3, 4: begin
                  lo = base + $urandom_range(0, 65535);
                  hi = lo + $urandom_range(0, 8);
               end
               5: begin
                  lo = rand_off();
                  hi = lo - $urandom_range(0, 3);
               end
               6: begin
                  lo = rand_off();
                  hi = rand_off();
               end
               default: begin
                  lo = rand_off();
                  hi = OFF_MAX;
               end
            endcase
         end else if (sel < 5 && held_cnt[GEN] > 0) begin
            idx = $urandom_range(0, held_cnt[GEN] - 1);
            lo = held_lo[GEN][idx];
            hi = held_hi[GEN][idx];
         end else if (sel == 5 && held_cnt[GEN] > 0) begin
            // near miss of a held entry
            idx = $urandom_range(0, held_cnt[GEN] - 1);
            lo = held_lo[GEN][idx];
            hi = held_hi[GEN][idx] + 1;
         end else if (sel == 6) begin
            lo = rand_off();
            hi = rand_off();
         end else begin
            lo = base + $urandom_range(0, 300);
            hi = lo + $urandom_range(0, 20);
         end
         add_req(md, lo, hi, $urandom_range(0, 119) == 0);
      end

      while (reset) @(posedge clock);
      while (lock_request_q.size() > 0 || req_valid) @(posedge clock);
      while (lock_status_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && lock_status_q.size() == 0) begin
         $display("PASS byte_range_lock_table_unit");
      end else begin
         $display("FAIL byte_range_lock_table_unit");
      end
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
